// ===== sv/crcp_pkg.sv =====
package crcp_pkg;

   typedef enum logic [1:0] {
      PH_WAIT  = 2'd0,
      PH_START = 2'd1,
      PH_BODY  = 2'd2,
      PH_CRC   = 2'd3
   } phase_type;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_READ = 2'd2;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   localparam logic [1:0] CSR_START_BYTE = 2'd0;
   localparam logic [1:0] CSR_MAX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   localparam logic [7:0]  START_BYTE_RST = 8'h02;
   localparam logic [7:0]  MAX_LENGTH_RST = 8'd251;
   localparam logic [15:0] TIMEOUT_RST    = 16'd100;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] IDLE_MAX = 16'hFFFF;

   // CRC-16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/crcp_if.sv =====
interface crcp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   logic [7:0] read_index;

   modport source (output valid, func, data_byte, read_index, input ready);
   modport sink (input valid, func, data_byte, read_index, output ready);
endinterface

interface crcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] cmd_id;
   logic [7:0] payload_len;
   logic [7:0] read_data;

   modport source (output valid, kind, cmd_id, payload_len, read_data, input ready);
   modport sink (input valid, kind, cmd_id, payload_len, read_data, output ready);
endinterface

// ===== sv/crcp_ram.sv =====
module crcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/crc16_framed_packet_receiver_unit.sv =====
// Channel    | Dir | Handshake    | Payload
// req_ch     | in  | valid/ready  | func, data_byte, read_index
// rsp_ch     | out | valid/ready  | kind, cmd_id, payload_len, read_data
// csr_*      | in  | write enable | csr_index, csr_wr_data
//
// One request per cycle while req_ch.ready is high; a result is registered in the pending
// stage (with the body buffer read), then in the output register.
// Reset (synchronous) restores register defaults and the parser; body buffer is not cleared.
// A result stalled at rsp_ch holds one more in the pending stage, then req_ch.ready drops.
module crc16_framed_packet_receiver_unit #(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data,
   crcp_req_if.sink          req_ch,
   crcp_rsp_if.source        rsp_ch
);
   import crcp_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int RECIP = (65536 + BUFFER_DEPTH - 1) / BUFFER_DEPTH;
   localparam logic [15:0] RECIP_C = 16'(RECIP);
   localparam logic [8:0]  DEPTH_C = 9'(BUFFER_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

   logic [7:0]  start_byte_ff, max_length_ff;
   logic [15:0] timeout_ff;

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  idx_ff, idx_in;
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;
   logic        crc_cnt_ff, crc_cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] idle_ff, idle_in;

   logic        p_valid_ff, p_valid_in;
   logic        p_kind_ff, p_kind_in;
   logic [7:0]  p_len_ff, p_len_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_cmd_ff, rsp_cmd_in;
   logic [7:0]  rsp_len_ff, rsp_len_in;
   logic [7:0]  rsp_data_ff, rsp_data_in;

   logic          out_free, accept, has_result;
   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;
   logic [23:0]   rd_prod;
   logic [7:0]    rd_quot;
   logic [16:0]   rd_rem;
   logic [AW-1:0] rd_addr;
   logic [15:0]   idle_inc;
   logic [7:0]    idx_inc;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !p_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // read_index modulo depth by reciprocal multiply (exact for 8-bit indexes)
   assign rd_prod = 24'(req_ch.read_index) * 24'(RECIP_C);
   assign rd_quot = rd_prod[23:16];
   assign rd_rem  = 17'(req_ch.read_index) - 17'(rd_quot) * 17'(DEPTH_C);
   assign rd_addr = rd_rem[AW-1:0];

   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
   assign idx_inc  = idx_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RST;
         max_length_ff <= MAX_LENGTH_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wr_data[7:0];
            CSR_MAX_LENGTH: max_length_ff <= csr_wr_data[7:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      wptr_in    = wptr_ff;
      crc_hi_in  = crc_hi_ff;
      crc_cnt_in = crc_cnt_ff;
      crc_in     = crc_ff;
      idle_in    = idle_ff;
      has_result = 1'b0;
      p_kind_in  = p_kind_ff;
      p_len_in   = p_len_ff;
      ram_we     = 1'b0;
      ram_raddr  = rd_addr;

      if (accept) begin
         unique case (req_ch.func)
            FUNC_TICK: begin
               idle_in = idle_inc;
               if (phase_ff != PH_WAIT && idle_inc > timeout_ff) begin
                  phase_in   = PH_WAIT;
                  len_in     = 8'd0;
                  idx_in     = 8'd0;
                  crc_hi_in  = 8'd0;
                  crc_cnt_in = 1'b0;
                  crc_in     = CRC_INIT;
               end
            end
            FUNC_READ: begin
               has_result = 1'b1;
               p_kind_in  = KIND_READ;
               p_len_in   = 8'd0;
            end
            FUNC_BYTE: begin
               idle_in = 16'd0;
               unique case (phase_ff)
                  PH_WAIT: begin
                     if (req_ch.data_byte == start_byte_ff) begin
                        phase_in = PH_START;
                     end
                  end
                  PH_START: begin
                     if (req_ch.data_byte != 8'd0 && req_ch.data_byte <= max_length_ff) begin
                        len_in     = req_ch.data_byte;
                        idx_in     = 8'd0;
                        wptr_in    = '0;
                        crc_cnt_in = 1'b0;
                        crc_in     = crc_step(CRC_INIT, req_ch.data_byte);
                        phase_in   = PH_BODY;
                     end else begin
                        phase_in   = PH_WAIT;
                        len_in     = 8'd0;
                        idx_in     = 8'd0;
                        crc_hi_in  = 8'd0;
                        crc_cnt_in = 1'b0;
                        crc_in     = CRC_INIT;
                     end
                  end
                  PH_BODY: begin
                     ram_we  = 1'b1;
                     crc_in  = crc_step(crc_ff, req_ch.data_byte);
                     idx_in  = idx_inc;
                     wptr_in = (wptr_ff == LAST_ADDR) ? '0 : wptr_ff + AW'(1);
                     if (idx_inc >= len_ff) begin
                        phase_in   = PH_CRC;
                        crc_cnt_in = 1'b0;
                     end
                  end
                  PH_CRC: begin
                     if (!crc_cnt_ff) begin
                        crc_hi_in  = req_ch.data_byte;
                        crc_cnt_in = 1'b1;
                     end else begin
                        if ({crc_hi_ff, req_ch.data_byte} == crc_ff) begin
                           has_result = 1'b1;
                           p_kind_in  = KIND_FRAME;
                           p_len_in   = len_ff - 8'd1;
                           ram_raddr  = '0;
                        end
                        phase_in   = PH_WAIT;
                        len_in     = 8'd0;
                        idx_in     = 8'd0;
                        crc_hi_in  = 8'd0;
                        crc_cnt_in = 1'b0;
                        crc_in     = CRC_INIT;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end

      p_valid_in = p_valid_ff;
      if (req_ch.ready) begin
         p_valid_in = accept && has_result;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = p_valid_ff;
         rsp_kind_in  = p_kind_ff;
         rsp_len_in   = p_len_ff;
         rsp_cmd_in   = (p_kind_ff == KIND_FRAME) ? ram_rdata : 8'd0;
         rsp_data_in  = (p_kind_ff == KIND_READ) ? ram_rdata : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         len_ff       <= 8'd0;
         idx_ff       <= 8'd0;
         wptr_ff      <= '0;
         crc_hi_ff    <= 8'd0;
         crc_cnt_ff   <= 1'b0;
         crc_ff       <= CRC_INIT;
         idle_ff      <= 16'd0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         wptr_ff      <= wptr_in;
         crc_hi_ff    <= crc_hi_in;
         crc_cnt_ff   <= crc_cnt_in;
         crc_ff       <= crc_in;
         idle_ff      <= idle_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_kind_ff   <= p_kind_in;
      p_len_ff    <= p_len_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_cmd_ff  <= rsp_cmd_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_data_ff <= rsp_data_in;
   end

   crcp_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_body_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wptr_ff),
      .wdata (req_ch.data_byte),
      .re    (accept),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.cmd_id      = rsp_cmd_ff;
   assign rsp_ch.payload_len = rsp_len_ff;
   assign rsp_ch.read_data   = rsp_data_ff;

   a_read_makes_pending: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.func == FUNC_READ |=> p_valid_ff && p_kind_ff == KIND_READ)
      else $error("read request produced no pending result");

   a_tick_no_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.func == FUNC_TICK |=> !p_valid_ff)
      else $error("tick request produced a result");

   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      p_valid_ff && !out_free |=> p_valid_ff && $stable(p_kind_ff) && $stable(p_len_ff))
      else $error("pending result lost under stall");

   a_wait_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> crc_ff == CRC_INIT && !crc_cnt_ff)
      else $error("parser idle with stale crc state");

   a_reset_state: assert property (@(posedge clock)
      reset |=> phase_ff == PH_WAIT && !rsp_valid_ff && !p_valid_ff)
      else $error("reset did not clear parser");

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import crcp_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400_000;

   typedef struct {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic [7:0] read_index;
   } req_item_t;

   typedef struct packed {
      logic       kind;
      logic [7:0] cmd_id;
      logic [7:0] payload_len;
      logic [7:0] read_data;
   } rsp_item_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_START_BYTE;
   logic [15:0] csr_wr_data = '0;

   crcp_req_if req_ch();
   crcp_rsp_if rsp_ch();

   crc16_framed_packet_receiver_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   always #5 clock = ~clock;

   // register copies
   logic [7:0]  cfg_start = START_BYTE_RST;
   logic [7:0]  cfg_max = MAX_LENGTH_RST;
   logic [15:0] cfg_timeout = TIMEOUT_RST;

   // parser copy
   phase_type   rx_phase = PH_WAIT;
   logic [7:0]  frame_len = '0;
   logic [7:0]  body_idx = '0;
   logic [7:0]  crc_hi = '0;
   logic        crc_count = 1'b0;
   logic [15:0] crc_acc = CRC_INIT;
   logic [15:0] idle_ticks = '0;
   logic [7:0]  body_mem [256];
   bit          body_written [256];

   req_item_t req_backlog [$];
   rsp_item_t predicted_replies [$];

   bit req_taken = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp_req = 1'b0;
   bit hold_rsp_done = 1'b0;
   int hold_left = 0;

   int errors = 0;
   int cycles = 0;
   int requests_queued = 0;
   int frames_seen = 0;
   int reads_seen = 0;
   int settings_used = 1;

   function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {b, 8'h00};
      repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      return r;
   endfunction

   function automatic void clear_parser();
      rx_phase = PH_WAIT;
      frame_len = '0;
      body_idx = '0;
      crc_hi = '0;
      crc_count = 1'b0;
      crc_acc = CRC_INIT;
   endfunction

   task automatic parse_request(input logic [1:0] func, input logic [7:0] b,
                                input logic [7:0] ri);
      rsp_item_t r;
      logic [7:0] len;
      r = '0;
      case (func)
         FUNC_TICK: begin
            if (idle_ticks != IDLE_MAX) idle_ticks++;
            if (rx_phase != PH_WAIT && idle_ticks > cfg_timeout) clear_parser();
         end
         FUNC_READ: begin
            r.kind = KIND_READ;
            r.read_data = body_mem[ri];
            predicted_replies.push_back(r);
         end
         FUNC_BYTE: begin
            idle_ticks = '0;
            case (rx_phase)
               PH_WAIT: begin
                  if (b == cfg_start) rx_phase = PH_START;
               end
               PH_START: begin
                  if (b != 8'd0 && b <= cfg_max) begin
                     frame_len = b;
                     body_idx = '0;
                     crc_count = 1'b0;
                     crc_acc = crc16_ccitt_next(CRC_INIT, b);
                     rx_phase = PH_BODY;
                  end else begin
                     clear_parser();
                  end
               end
               PH_BODY: begin
                  body_mem[body_idx] = b;
                  body_written[body_idx] = 1'b1;
                  crc_acc = crc16_ccitt_next(crc_acc, b);
                  body_idx = body_idx + 8'd1;
                  if (body_idx >= frame_len) begin
                     rx_phase = PH_CRC;
                     crc_count = 1'b0;
                  end
               end
               default: begin
                  if (!crc_count) begin
                     crc_hi = b;
                     crc_count = 1'b1;
                  end else begin
                     len = frame_len;
                     if ({crc_hi, b} == crc_acc) begin
                        r.kind = KIND_FRAME;
                        r.cmd_id = body_mem[0];
                        r.payload_len = len - 8'd1;
                        predicted_replies.push_back(r);
                     end
                     clear_parser();
                  end
               end
            endcase
         end
         default: ;
      endcase
   endtask

   task automatic check_reply();
      rsp_item_t got, want;
      got.kind = rsp_ch.kind;
      got.cmd_id = rsp_ch.cmd_id;
      got.payload_len = rsp_ch.payload_len;
      got.read_data = rsp_ch.read_data;
      if (predicted_replies.size() == 0) begin
         $error("unexpected result: kind %0d cmd_id %0h payload_len %0d read_data %0h",
                got.kind, got.cmd_id, got.payload_len, got.read_data);
         errors++;
      end else begin
         want = predicted_replies.pop_front();
         if (want.kind == KIND_FRAME) frames_seen++;
         else reads_seen++;
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.cmd_id !== want.cmd_id) begin
            $error("cmd_id: expected %0h, got %0h", want.cmd_id, got.cmd_id);
            errors++;
         end
         if (got.payload_len !== want.payload_len) begin
            $error("payload_len: expected %0d, got %0d", want.payload_len, got.payload_len);
            errors++;
         end
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            errors++;
         end
      end
   endtask

   // monitor: prediction on accepted requests, checking on accepted results
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready)
            parse_request(req_ch.func, req_ch.data_byte, req_ch.read_index);
         if (rsp_ch.valid && rsp_ch.ready) check_reply();
      end
   end

   // driver; read indexes are resolved when offered so only written entries are read
   always @(negedge clock) begin
      req_item_t nxt;
      int n_written;
      int pick;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_taken) void'(req_backlog.pop_front());
         if (req_ch.valid && !req_taken) begin
            // hold until taken
         end else if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = req_backlog[0];
            if (nxt.func == FUNC_READ) begin
               n_written = 0;
               for (int i = 0; i < 256; i++) if (body_written[i]) n_written++;
               if (n_written == 0) begin
                  nxt.func = FUNC_TICK;
               end else begin
                  pick = $urandom_range(n_written - 1);
                  for (int i = 0; i < 256; i++) begin
                     if (body_written[i]) begin
                        if (pick == 0) nxt.read_index = 8'(i);
                        pick--;
                     end
                  end
               end
               req_backlog[0] = nxt;
            end
            req_ch.valid <= 1'b1;
            req_ch.func <= nxt.func;
            req_ch.data_byte <= nxt.data_byte;
            req_ch.read_index <= nxt.read_index;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_rsp_req && !hold_rsp_done) begin
         hold_rsp_done = 1'b1;
         hold_left = 60;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("crc16_framed_packet_receiver_unit: mismatch");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] func, input logic [7:0] b, input logic [7:0] ri);
      req_backlog.push_back('{func, b, ri});
      if (func != FUNC_UNUSED) requests_queued++;
   endtask

   task automatic push_byte(input logic [7:0] b);
      push_req(FUNC_BYTE, b, 8'($urandom_range(255)));
   endtask

   task automatic push_ticks(input int n);
      repeat (n) push_req(FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic push_read();
      push_req(FUNC_READ, 8'($urandom_range(255)), 8'h00);
   endtask

   // start, length, command + payload, CRC; optional idle ticks at a random spot
   task automatic push_frame(input logic [7:0] cmd, input int plen, input bit bad_crc,
                             input int mid_ticks);
      logic [7:0]  frame_bytes [$];
      logic [15:0] crc;
      int          cut;
      frame_bytes.push_back(cfg_start);
      frame_bytes.push_back(8'(plen + 1));
      frame_bytes.push_back(cmd);
      repeat (plen) frame_bytes.push_back(8'($urandom_range(255)));
      crc = CRC_INIT;
      for (int i = 1; i < frame_bytes.size(); i++) crc = crc16_ccitt_next(crc, frame_bytes[i]);
      if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
      frame_bytes.push_back(crc[15:8]);
      frame_bytes.push_back(crc[7:0]);
      cut = (mid_ticks != 0) ? $urandom_range(1, frame_bytes.size() - 1) : 0;
      foreach (frame_bytes[i]) begin
         if (mid_ticks != 0 && i == cut) push_ticks(mid_ticks);
         push_byte(frame_bytes[i]);
      end
   endtask

   task automatic run_traffic(input int target);
      int stop_at;
      int pick;
      int max_plen;
      int short_plen;
      int mid;
      stop_at = requests_queued + target;
      max_plen = int'(cfg_max) - 1;
      short_plen = (max_plen < 7) ? max_plen : 7;
      while (requests_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            mid = 0;
            if (cfg_timeout != 0 && $urandom_range(3) == 0)
               mid = $urandom_range(1, (cfg_timeout < 3) ? int'(cfg_timeout) : 3);
            push_frame(8'($urandom_range(255)),
                       ($urandom_range(9) == 0) ? $urandom_range(max_plen)
                                                : $urandom_range(short_plen),
                       1'b0, mid);
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 3)) push_read();
         end else if (pick < 78) begin
            push_ticks($urandom_range(1, 5));
         end else if (pick < 90) begin
            case ($urandom_range(2))
               0: push_frame(8'($urandom_range(255)), $urandom_range(short_plen), 1'b1, 0);
               1: begin
                  push_byte(cfg_start);
                  push_byte($urandom_range(1) ? 8'(cfg_max + 8'd1) : 8'h00);
               end
               default: begin
                  if (cfg_timeout <= 120) begin
                     // truncated frame, abandoned by the idle timeout
                     push_byte(cfg_start);
                     push_byte(8'($urandom_range(1, cfg_max)));
                     push_byte(8'($urandom_range(255)));
                     push_ticks(int'(cfg_timeout) + 1);
                  end else begin
                     push_frame(8'($urandom_range(255)), $urandom_range(short_plen), 1'b1, 0);
                  end
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 4))
               push_req(($urandom_range(3) == 0) ? FUNC_UNUSED : FUNC_BYTE,
                        8'($urandom_range(255)), 8'($urandom_range(255)));
            if (cfg_timeout <= 120) push_ticks(int'(cfg_timeout) + 1);
         end
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_START_BYTE: cfg_start = val[7:0];
         CSR_MAX_LENGTH: cfg_max = val[7:0];
         CSR_TIMEOUT:    cfg_timeout = val;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [7:0] sb, input logic [7:0] ml, input logic [15:0] to);
      write_csr(CSR_START_BYTE, {8'h00, sb});
      write_csr(CSR_MAX_LENGTH, {8'h00, ml});
      write_csr(CSR_TIMEOUT, to);
      settings_used++;
   endtask

   task automatic drain();
      while (req_backlog.size() != 0 || predicted_replies.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_BYTE;
      req_ch.data_byte = '0;
      req_ch.read_index = '0;
      rsp_ch.ready = 1'b0;
      clear_parser();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 24;
      recv_idle_pct = 68;
      // reset defaults: good frames, bad CRC, length zero and above max, unused func
      push_req(FUNC_UNUSED, 8'hFF, 8'hFF);
      push_frame(8'hFF, 0, 1'b0, 0);
      push_frame(8'h00, 2, 1'b1, 0);
      push_byte(cfg_start);
      push_byte(8'h00);
      push_byte(cfg_start);
      push_byte(cfg_max + 8'd1);
      push_read();
      push_frame(8'h00, 2, 1'b0, 1);
      drain();

      write_csr(CSR_MAX_LENGTH, 16'd1);
      write_csr(CSR_TIMEOUT, 16'd1);
      settings_used++;
      // length byte equal to the start byte but out of range
      push_byte(cfg_start);
      push_byte(cfg_start);
      push_frame(8'h5A, 0, 1'b0, 1);
      push_frame(8'hA5, 0, 1'b0, 2);
      push_read();
      drain();

      configure(8'h00, 8'd254, 16'd0);
      run_traffic(100);
      drain();

      send_idle_pct = 68;
      recv_idle_pct = 24;
      configure(8'hFF, 8'd1, 16'hFFFF);
      run_traffic(100);
      drain();

      configure(8'($urandom_range(255)), 8'($urandom_range(1, 254)), 16'($urandom_range(2, 20)));
      run_traffic(100);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(START_BYTE_RST, MAX_LENGTH_RST, TIMEOUT_RST);
      hold_rsp_req = 1'b1;
      repeat (40) push_read();
      run_traffic(100);
      drain();

      // the largest timeout keeps a frame open across a long idle stretch
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      push_frame(8'($urandom_range(255)), 1, 1'b0, 120);
      drain();

      $display("%0d requests over %0d register settings; %0d frames and %0d reads checked",
               requests_queued, settings_used, frames_seen, reads_seen);
      if (errors == 0) begin
         $display("crc16_framed_packet_receiver_unit: match");
      end else begin
         $display("crc16_framed_packet_receiver_unit: mismatch");
      end
      $finish;
   end

endmodule
